@@ hdl/gmhp_pkg.sv @@
// ----------------------------------------------------------------------------
// gmhp_pkg
// Shared types, status codes and the byte-wide CRC-32 update used by the
// gzip member header parser.
// ----------------------------------------------------------------------------
package gmhp_pkg;

    localparam int unsigned OffsetWidth = 32;
    localparam int unsigned StatusWidth = 3;

    localparam logic [StatusWidth-1:0] ST_OK        = 3'd0;
    localparam logic [StatusWidth-1:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [StatusWidth-1:0] ST_BAD_CM    = 3'd2;
    localparam logic [StatusWidth-1:0] ST_RSVD_FLAG = 3'd3;
    localparam logic [StatusWidth-1:0] ST_TRUNCATED = 3'd4;
    localparam logic [StatusWidth-1:0] ST_HDR_CRC   = 3'd5;
    localparam logic [StatusWidth-1:0] ST_TOO_LONG  = 3'd6;

    localparam logic [7:0]  GZ_ID1       = 8'h1F;
    localparam logic [7:0]  GZ_ID2       = 8'h8B;
    localparam logic [7:0]  GZ_CM_DEFL   = 8'h08;
    localparam logic [7:0]  GZ_FLG_RSVD  = 8'hE0;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;

    // flag bit positions
    localparam int unsigned FLG_FHCRC    = 1;
    localparam int unsigned FLG_FEXTRA   = 2;
    localparam int unsigned FLG_FNAME    = 3;
    localparam int unsigned FLG_FCOMMENT = 4;

    typedef struct packed {
        logic                   hit;
        logic [StatusWidth-1:0] status;
        logic [OffsetWidth-1:0] offset;
    } t_verdict;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ hdl/gzip_member_header_parser_core.sv @@
// ----------------------------------------------------------------------------
// gzip_member_header_parser_core
// Byte-stream gzip member header checker with registered input and output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one byte per transfer with
//   first and last marks. i_first_byte restarts the parser on byte 0.
//   Output channel: o_out_valid / i_out_stall carry one verdict per member
//   (o_status, o_payload_offset). Bytes after a verdict give nothing until
//   the next first mark.
//   Throughput: one byte per cycle while unstalled. The byte passes an input
//   register, then the header state machine and CRC update, into the result
//   register. o_out_valid rises as the byte that decides the verdict leaves
//   the input register; the result transfer can happen at the next edge.
//   When the receiver stalls with a verdict held, the byte in the input
//   register waits and o_in_stall rises; one more byte is still taken while
//   the input register is empty.
//   Reset (synchronous, active low) empties both registers and puts the
//   parser in idle, waiting for a first mark.
// ----------------------------------------------------------------------------
module gzip_member_header_parser_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_first_byte,
    input  logic                           i_last_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [gmhp_pkg::StatusWidth-1:0] o_status,
    output logic [gmhp_pkg::OffsetWidth-1:0] o_payload_offset
);
    import gmhp_pkg::*;

    logic                   r_in_valid;
    logic [7:0]             r_byte;
    logic                   r_first;
    logic                   r_last;
    logic                   r_out_valid;
    logic [StatusWidth-1:0] r_status;
    logic [OffsetWidth-1:0] r_offset;

    logic     out_free;
    logic     proc;
    logic     in_xfer;
    t_verdict verdict;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    gmhp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (proc),
        .i_data_byte  (r_byte),
        .i_first_byte (r_first),
        .i_last_byte  (r_last),
        .o_verdict    (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= proc && verdict.hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_byte  <= i_data_byte;
            r_first <= i_first_byte;
            r_last  <= i_last_byte;
        end
        if (out_free) begin
            r_status <= verdict.status;
            r_offset <= verdict.offset;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_payload_offset = r_offset;

endmodule

@@ hdl/gmhp_parser.sv @@
// ----------------------------------------------------------------------------
// gmhp_parser
// Header state machine: consumes one byte per enabled cycle, keeps the
// parse state and running CRC, and reports a verdict when one is reached.
// ----------------------------------------------------------------------------
module gmhp_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [7:0]         i_data_byte,
    input  logic               i_first_byte,
    input  logic               i_last_byte,
    output gmhp_pkg::t_verdict o_verdict
);
    import gmhp_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ID1     = 4'd1,
        PH_ID2     = 4'd2,
        PH_CM      = 4'd3,
        PH_FLG     = 4'd4,
        PH_FIX     = 4'd5,
        PH_XLEN0   = 4'd6,
        PH_XLEN1   = 4'd7,
        PH_EXTRA   = 4'd8,
        PH_NAME    = 4'd9,
        PH_COMMENT = 4'd10,
        PH_HCRC0   = 4'd11,
        PH_HCRC1   = 4'd12,
        PH_TAIL    = 4'd13
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [4:0]  r_flags, n_flags;
    logic [15:0] r_xrem, n_xrem;
    logic [31:0] r_crc, n_crc;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic [3:0]  r_tail, n_tail;
    t_verdict    verdict;

    // first optional field at or after 'from' enabled by the flags, else the tail
    function automatic t_phase next_field(input t_phase from, input logic [4:0] flg);
        if (from <= PH_XLEN0 && flg[FLG_FEXTRA])        return PH_XLEN0;
        else if (from <= PH_NAME && flg[FLG_FNAME])     return PH_NAME;
        else if (from <= PH_COMMENT && flg[FLG_FCOMMENT]) return PH_COMMENT;
        else if (from <= PH_HCRC0 && flg[FLG_FHCRC])    return PH_HCRC0;
        else                                            return PH_TAIL;
    endfunction

    always_comb begin
        t_phase      ph;
        logic [31:0] pos;
        logic [4:0]  flg;
        logic [15:0] xrem;
        logic [31:0] crc;
        logic [7:0]  crc_lo;
        logic [3:0]  tail;
        logic        active;

        if (i_first_byte) begin
            ph     = PH_ID1;
            pos    = '0;
            flg    = '0;
            xrem   = '0;
            crc    = CRC_INIT;
            crc_lo = '0;
            tail   = '0;
        end else begin
            ph     = r_phase;
            pos    = r_pos;
            flg    = r_flags;
            xrem   = r_xrem;
            crc    = r_crc;
            crc_lo = r_crc_lo;
            tail   = r_tail;
        end
        active = i_first_byte || (r_phase != PH_IDLE);

        verdict = '0;
        n_phase  = ph;
        n_flags  = flg;
        n_xrem   = xrem;
        n_crc    = crc;
        n_crc_lo = crc_lo;
        n_tail   = tail;
        n_pos    = pos;

        if (active) begin
            if (pos == 32'hFFFF_FFFF) begin
                verdict.hit    = 1'b1;
                verdict.status = ST_TOO_LONG;
            end else begin
                if (ph >= PH_ID1 && ph <= PH_COMMENT) begin
                    n_crc = crc_byte(crc, i_data_byte);
                end
                case (ph)
                    PH_ID1: begin
                        if (i_data_byte != GZ_ID1) begin
                            verdict.hit = 1'b1; verdict.status = ST_BAD_MAGIC;
                        end else begin
                            n_phase = PH_ID2;
                        end
                    end
                    PH_ID2: begin
                        if (i_data_byte != GZ_ID2) begin
                            verdict.hit = 1'b1; verdict.status = ST_BAD_MAGIC;
                        end else begin
                            n_phase = PH_CM;
                        end
                    end
                    PH_CM: begin
                        if (i_data_byte != GZ_CM_DEFL) begin
                            verdict.hit = 1'b1; verdict.status = ST_BAD_CM;
                        end else begin
                            n_phase = PH_FLG;
                        end
                    end
                    PH_FLG: begin
                        if ((i_data_byte & GZ_FLG_RSVD) != 8'd0) begin
                            verdict.hit = 1'b1; verdict.status = ST_RSVD_FLAG;
                        end else begin
                            n_flags = i_data_byte[4:0];
                            n_phase = PH_FIX;
                        end
                    end
                    PH_FIX: begin
                        // MTIME, XFL, OS end at byte 9
                        if (pos >= 32'd9) n_phase = next_field(PH_XLEN0, flg);
                    end
                    PH_XLEN0: begin
                        n_xrem  = {8'd0, i_data_byte};
                        n_phase = PH_XLEN1;
                    end
                    PH_XLEN1: begin
                        n_xrem  = {i_data_byte, xrem[7:0]};
                        n_phase = (n_xrem != 16'd0) ? PH_EXTRA : next_field(PH_NAME, flg);
                    end
                    PH_EXTRA: begin
                        n_xrem = xrem - 16'd1;
                        if (n_xrem == 16'd0) n_phase = next_field(PH_NAME, flg);
                    end
                    PH_NAME: begin
                        if (i_data_byte == 8'd0) n_phase = next_field(PH_COMMENT, flg);
                    end
                    PH_COMMENT: begin
                        if (i_data_byte == 8'd0) n_phase = next_field(PH_HCRC0, flg);
                    end
                    PH_HCRC0: begin
                        n_crc_lo = i_data_byte;
                        n_phase  = PH_HCRC1;
                    end
                    PH_HCRC1: begin
                        if (~crc[15:0] != {i_data_byte, crc_lo}) begin
                            verdict.hit = 1'b1; verdict.status = ST_HDR_CRC;
                        end else begin
                            n_phase = PH_TAIL;
                        end
                    end
                    PH_TAIL: begin
                        n_tail = tail + 4'd1;
                        if (n_tail >= 4'd8) begin
                            verdict.hit    = 1'b1;
                            verdict.status = ST_OK;
                            verdict.offset = pos - 32'd7;
                        end
                    end
                    default: begin
                        n_phase = ph;
                    end
                endcase
                if (!verdict.hit && i_last_byte) begin
                    verdict.hit    = 1'b1;
                    verdict.status = ST_TRUNCATED;
                end
                n_pos = pos + 32'd1;
            end
            if (verdict.hit) n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_pos    <= '0;
            r_flags  <= '0;
            r_xrem   <= '0;
            r_crc    <= CRC_INIT;
            r_crc_lo <= '0;
            r_tail   <= '0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_flags  <= n_flags;
            r_xrem   <= n_xrem;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
            r_tail   <= n_tail;
        end
    end

    assign o_verdict = verdict;

endmodule
